@@ design/fuc_pkg.sv @@
package fuc_pkg;

    // Configuration register map (word index)
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam logic        REG_MODE = 1'b0;

    // Mode register values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Characters with special meaning
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CH_LC_Z    = 8'h7A;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_F    = 8'h46;
    localparam logic [7:0] CH_UC_Z    = 8'h5A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_USCORE  = 8'h5F;

    // Decoded byte values for malformed escapes
    localparam logic [7:0] BAD_BOTH   = 8'hFF;
    localparam logic [3:0] BAD_HIGH   = 4'hF;

    // Escape tracking in decode mode
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DIGIT1 = 2'd1,
        PH_DIGIT2 = 2'd2
    } esc_phase_t;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_end;
        logic       string_end;
        logic       error;
    } out_item_t;

    // Hex digit value; bit 4 set flags a byte that is no hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] b);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                t = b - CH_ZERO;
            end else if (b >= CH_LC_A && b <= CH_LC_F) begin
                t = b - CH_LC_A + 8'd10;
            end else if (b >= CH_UC_A && b <= CH_UC_F) begin
                t = b - CH_UC_A + 8'd10;
            end else begin
                t = 8'd16;
            end
            return t[4:0];
        end
    endfunction

    // Lowercase hex character for a nibble
    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        begin
            if (n < 4'd10) begin
                return CH_ZERO + {4'd0, n};
            end
            return CH_LC_A - 8'd10 + {4'd0, n};
        end
    endfunction

    // Bytes that go through encoding unchanged
    function automatic logic passes(input logic [7:0] b);
        begin
            return (b >= CH_LC_A && b <= CH_LC_Z) ||
                   (b >= CH_UC_A && b <= CH_UC_Z) ||
                   (b >= CH_ZERO && b <= CH_NINE) ||
                   b == CH_DASH || b == CH_COMMA || b == CH_DOT ||
                   b == CH_AT || b == CH_USCORE;
        end
    endfunction

endpackage

@@ design/form_url_codec.sv @@
// Form-urlencoding codec on a byte stream. Write mode (offset 0x0, bit 0) while
// idle: 0 encodes, 1 decodes; a mode write also drops any partial escape. One
// input byte is taken per cycle and one result byte leaves per cycle through
// the output register unless stalled; pass-through bytes, spaces and all decode
// traffic run at that rate, but an encoded escape ('%' and two hex digits)
// holds the input for its three bytes. In decode mode '%' and the first digit
// produce no result; a string whose last byte falls inside an escape yields a
// single result with error set and must be discarded downstream.
module form_url_codec
    import fuc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Input byte stream
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    // Result byte stream
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    logic       mode_reg;
    logic       cfg_wr;

    logic       in_valid_reg;
    in_item_t   in_data_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    esc_phase_t esc_reg;
    esc_phase_t esc_next;
    logic [4:0] fd_reg;
    logic [4:0] fd_next;

    logic       m_valid_reg;
    out_item_t  m_data_reg;

    logic [1:0] res_count;
    out_item_t  res;
    logic       res_last;
    logic       out_load;
    logic       in_consume;

    logic [7:0] b;
    logic       last;
    logic [4:0] dv;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign prdata = (paddr[2] == REG_MODE) ? {{(PDATA_W-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
        end else if (cfg_wr) begin
            mode_reg <= pwdata[0];
        end
    end

    // Results of the held byte; idx_reg picks the one being emitted
    assign b    = in_data_reg.in_byte;
    assign last = in_data_reg.in_last;
    assign dv   = digit_value(b);

    always_comb begin
        res_count = 2'd0;
        res       = '0;
        esc_next  = esc_reg;
        fd_next   = fd_reg;
        if (mode_reg == MODE_ENCODE) begin
            if (passes(b)) begin
                res_count    = 2'd1;
                res.out_byte = b;
            end else if (b == CH_SPACE) begin
                res_count    = 2'd1;
                res.out_byte = CH_PLUS;
            end else begin
                res_count = 2'd3;
                case (idx_reg)
                    2'd0:    res.out_byte = CH_PERCENT;
                    2'd1:    res.out_byte = nibble_char(b[7:4]);
                    default: res.out_byte = nibble_char(b[3:0]);
                endcase
            end
            res.item_end   = (idx_reg == res_count - 2'd1);
            res.string_end = last && res.item_end;
        end else begin
            unique case (esc_reg)
                PH_DIGIT1: begin
                    esc_next = PH_DIGIT2;
                    fd_next  = dv;
                end
                PH_DIGIT2: begin
                    res_count = 2'd1;
                    esc_next  = PH_IDLE;
                    fd_next   = 5'd0;
                    if (dv[4]) begin
                        res.out_byte = BAD_BOTH;
                    end else if (fd_reg[4]) begin
                        res.out_byte = {BAD_HIGH, dv[3:0]};
                    end else begin
                        res.out_byte = {fd_reg[3:0], dv[3:0]};
                    end
                    res.item_end   = 1'b1;
                    res.string_end = last;
                end
                default: begin
                    if (b == CH_PERCENT) begin
                        esc_next = PH_DIGIT1;
                        fd_next  = 5'd0;
                    end else begin
                        res_count      = 2'd1;
                        esc_next       = PH_IDLE;
                        res.out_byte   = (b == CH_PLUS) ? CH_SPACE : b;
                        res.item_end   = 1'b1;
                        res.string_end = last;
                    end
                end
            endcase
            // String ended inside an escape
            if (res_count == 2'd0 && last) begin
                res_count      = 2'd1;
                esc_next       = PH_IDLE;
                fd_next        = 5'd0;
                res.out_byte   = 8'd0;
                res.item_end   = 1'b1;
                res.string_end = 1'b1;
                res.error      = 1'b1;
            end
        end
    end

    // Handshake between input register and output register
    assign res_last   = (idx_reg == res_count - 2'd1);
    assign out_load   = in_valid_reg && (res_count != 2'd0) && (!m_valid_reg || m_ready);
    assign in_consume = in_valid_reg && ((res_count == 2'd0) || (out_load && res_last));
    assign s_ready    = !in_valid_reg || in_consume;

    always_comb begin
        idx_next = idx_reg;
        if (in_consume) begin
            idx_next = 2'd0;
        end else if (out_load) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (in_consume) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Decode escape state, advanced once per consumed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= PH_IDLE;
            fd_reg  <= 5'd0;
        end else if (cfg_wr) begin
            esc_reg <= PH_IDLE;
            fd_reg  <= 5'd0;
        end else if (in_consume) begin
            esc_reg <= esc_next;
            fd_reg  <= fd_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
